>>> rtl/core/rfb_pkg.sv
// Shared constants, codes and types of the radix-4 FFT butterfly engine.
package rfb_pkg;

  // Sample and table geometry (TW_DEPTH is a power of two)
  localparam int DATA_BITS = 16;
  localparam int TW_DEPTH  = 1024;
  localparam int TW_AW     = $clog2(TW_DEPTH);
  // A product of two full-scale negative values rounds to +2^(DATA_BITS),
  // so the rounded product needs two bits above the sample width
  localparam int PROD_BITS = DATA_BITS + 2;
  localparam int OUT_BITS  = DATA_BITS + 3;
  localparam int CFG_BITS  = 9;
  localparam int CFG_IDX_BITS = 1;
  localparam int SLOT_BITS = 10;
  localparam int CNT_BITS  = 8;
  localparam int LEN_MAX   = 256;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SUB_LENGTH     = 1'b0,
    REG_TWIDDLE_STRIDE = 1'b1
  } cfg_reg_e;

  typedef logic signed [DATA_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [OUT_BITS-1:0]  out_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cpx_t;

  typedef struct packed {
    prod_t re;
    prod_t im;
  } cprod_t;

  // Running twiddle addresses for points one to three
  typedef struct packed {
    logic [TW_AW-1:0] k1;
    logic [TW_AW-1:0] k2;
    logic [TW_AW-1:0] k3;
  } tw_idx_t;

endpackage

>>> rtl/core/rfb_if.sv
// Valid/ready channel interfaces for butterfly input and result words.
interface rfb_in_if import rfb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SLOT_BITS-1:0] twiddle_slot;
  sample_t              a_re;
  sample_t              a_im;
  sample_t              b_re;
  sample_t              b_im;
  sample_t              c_re;
  sample_t              c_im;
  sample_t              d_re;
  sample_t              d_im;

  modport source (
    output valid, command, twiddle_slot, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
    input  ready
  );
  modport sink (
    input  valid, command, twiddle_slot, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
    output ready
  );
endinterface

interface rfb_out_if import rfb_pkg::*; ();
  logic valid;
  logic ready;
  out_t y0_re;
  out_t y0_im;
  out_t y1_re;
  out_t y1_im;
  out_t y2_re;
  out_t y2_im;
  out_t y3_re;
  out_t y3_im;

  modport source (
    output valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im,
    input  ready
  );
  modport sink (
    input  valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im,
    output ready
  );
endinterface

>>> rtl/core/rfb_index_ctrl.sv
// Configuration registers, butterfly counter and running twiddle indices.
module rfb_index_ctrl import rfb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    adv_i,
  output tw_idx_t                 idx_o
);

  logic [CFG_BITS-1:0] sub_len_q;
  logic [CFG_BITS-1:0] stride_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  tw_idx_t             idx_q, idx_d;

  logic [CFG_BITS-1:0]       len;
  logic [CFG_BITS-1:0]       cnt_next;
  logic                      wrap;
  logic [TW_AW+CFG_BITS-1:0] stride_ext;
  logic [TW_AW-1:0]          step1, step2, step3;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_len_q <= CFG_BITS'(1);
      stride_q  <= CFG_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SUB_LENGTH:     sub_len_q <= cfg_data_i;
        REG_TWIDDLE_STRIDE: stride_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sub length to one .. LEN_MAX
  always_comb begin
    if (sub_len_q == '0) begin
      len = CFG_BITS'(1);
    end else if (sub_len_q > CFG_BITS'(LEN_MAX)) begin
      len = CFG_BITS'(LEN_MAX);
    end else begin
      len = sub_len_q;
    end
  end

  // Reduce stride modulo table depth and form the 2x and 3x steps
  assign stride_ext = {{TW_AW{1'b0}}, stride_q};
  assign step1      = stride_ext[TW_AW-1:0];
  assign step2      = {step1[TW_AW-2:0], 1'b0};
  assign step3      = step2 + step1;

  assign cnt_next = CFG_BITS'(cnt_q) + CFG_BITS'(1);
  assign wrap     = cnt_next >= len;

  // Advance or restart the indices on each butterfly
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (adv_i) begin
      if (wrap) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        cnt_d    = cnt_next[CNT_BITS-1:0];
        idx_d.k1 = idx_q.k1 + step1;
        idx_d.k2 = idx_q.k2 + step2;
        idx_d.k3 = idx_q.k3 + step3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  assign idx_o = idx_q;

  // The start of a group always reads the twiddles at index zero
  a_group_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (idx_q.k1 == '0 && idx_q.k2 == '0 && idx_q.k3 == '0))
    else $error("indices not zero at group start");

endmodule

>>> rtl/core/rfb_twiddle_store.sv
// Twiddle table in three banks, one read address each, written together.
module rfb_twiddle_store import rfb_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [TW_AW-1:0] waddr_i,
  input  cpx_t             wdata_i,
  input  logic             re_i,
  input  tw_idx_t          raddr_i,
  output cpx_t             w1_o,
  output cpx_t             w2_o,
  output cpx_t             w3_o
);

  cpx_t bank1_q [TW_DEPTH];
  cpx_t bank2_q [TW_DEPTH];
  cpx_t bank3_q [TW_DEPTH];
  cpx_t w1_q, w2_q, w3_q;

  // Mirror every load into all three banks
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      bank1_q[waddr_i] <= wdata_i;
      bank2_q[waddr_i] <= wdata_i;
      bank3_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while no butterfly is taken
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      w1_q <= bank1_q[raddr_i.k1];
      w2_q <= bank2_q[raddr_i.k2];
      w3_q <= bank3_q[raddr_i.k3];
    end
  end

  assign w1_o = w1_q;
  assign w2_o = w2_q;
  assign w3_o = w3_q;

endmodule

>>> rtl/core/rfb_cmul.sv
// Complex Q1.15 multiply with round-half-up and shift by DATA_BITS-1.
module rfb_cmul import rfb_pkg::*; (
  input  cpx_t   x_i,
  input  cpx_t   w_i,
  output cprod_t t_o
);

  localparam int MUL_BITS = 2 * DATA_BITS;
  localparam int SUM_BITS = 2 * DATA_BITS + 1;

  logic signed [MUL_BITS-1:0] rr, ii, ir, ri;
  logic signed [SUM_BITS-1:0] sum_re, sum_im;
  logic signed [SUM_BITS-1:0] bias;

  assign bias = SUM_BITS'(1) <<< (DATA_BITS - 2);

  // Form the four exact products
  assign rr = x_i.re * w_i.re;
  assign ii = x_i.im * w_i.im;
  assign ir = x_i.im * w_i.re;
  assign ri = x_i.re * w_i.im;

  // Combine, add half an LSB, keep the rounded bits
  assign sum_re = SUM_BITS'(rr) - SUM_BITS'(ii) + bias;
  assign sum_im = SUM_BITS'(ir) + SUM_BITS'(ri) + bias;

  assign t_o.re = sum_re[PROD_BITS+DATA_BITS-2:DATA_BITS-1];
  assign t_o.im = sum_im[PROD_BITS+DATA_BITS-2:DATA_BITS-1];

endmodule

>>> rtl/core/radix4_fft_butterfly.sv
// Top level of the radix-4 DIT FFT butterfly engine.
//
// Usage: words arrive on in_i (valid/ready). A load word (command 0) writes
// a_re/a_im into the twiddle table at twiddle_slot and yields no result;
// slots beyond the table are dropped. A compute word (command 1) carries
// x0..x3; x1..x3 are multiplied by the twiddles at the running indices
// k, 2k, 3k and the four butterfly outputs leave on out_o as one word.
// sub_length and twiddle_stride are set over the cfg port while idle.
// Path: a compute word passes the table read stage, the multiply stage and
// the butterfly/result stage in that order before it is offered on out_o.
// Throughput: one word per cycle while out_o takes results, set by the
// three-stage pipeline with a mirrored table bank per read address.
// Reset: counter and indices go to zero, sub_length and twiddle_stride to
// one, the pipeline empties; the table holds whatever was loaded.
// Stall: each stage holds only while the next one is full, so bubbles close
// up and in_i keeps taking words until all three stages are occupied.
module radix4_fft_butterfly import rfb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  rfb_in_if.sink                  in_i,
  rfb_out_if.source               out_o
);

  logic    acc, is_compute, do_load, do_compute;
  logic    en1, en2, en3;
  logic    v1_q, v2_q, v3_q;
  tw_idx_t idx;
  cpx_t    w1, w2, w3;

  logic [TW_AW+SLOT_BITS-1:0] slot_ext;
  logic                       slot_ok;

  cpx_t   x0_1_q, x1_1_q, x2_1_q, x3_1_q;
  cpx_t   x0_2_q;
  cprod_t t1, t2, t3;
  cprod_t t1_q, t2_q, t3_q;

  out_t x0r, x0i, t1r, t1i, t2r, t2i, t3r, t3i;
  out_t s0r, s0i, s5r, s5i, s3r, s3i, s4r, s4i;
  out_t y0r_q, y0i_q, y1r_q, y1i_q, y2r_q, y2i_q, y3r_q, y3i_q;

  // Stage enables: a stage moves when it is empty or the next one moves
  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;
  assign acc        = in_i.valid && en1;
  assign is_compute = cmd_e'(in_i.command) == CMD_COMPUTE;
  assign do_compute = acc && is_compute;

  // Drop loads aimed past the end of the table
  assign slot_ext = {{TW_AW{1'b0}}, in_i.twiddle_slot};
  assign slot_ok  = {{(32-SLOT_BITS){1'b0}}, in_i.twiddle_slot} < 32'(TW_DEPTH);
  assign do_load  = acc && !is_compute && slot_ok;

  rfb_index_ctrl u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (do_compute),
    .idx_o      (idx)
  );

  rfb_twiddle_store u_store (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (slot_ext[TW_AW-1:0]),
    .wdata_i ('{re: in_i.a_re, im: in_i.a_im}),
    .re_i    (do_compute),
    .raddr_i (idx),
    .w1_o    (w1),
    .w2_o    (w2),
    .w3_o    (w3)
  );

  // Valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= do_compute;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: capture the points alongside the table read
  always_ff @(posedge clk_i) begin
    if (do_compute) begin
      x0_1_q <= '{re: in_i.a_re, im: in_i.a_im};
      x1_1_q <= '{re: in_i.b_re, im: in_i.b_im};
      x2_1_q <= '{re: in_i.c_re, im: in_i.c_im};
      x3_1_q <= '{re: in_i.d_re, im: in_i.d_im};
    end
  end

  rfb_cmul u_cmul1 (.x_i(x1_1_q), .w_i(w1), .t_o(t1));
  rfb_cmul u_cmul2 (.x_i(x2_1_q), .w_i(w2), .t_o(t2));
  rfb_cmul u_cmul3 (.x_i(x3_1_q), .w_i(w3), .t_o(t3));

  // Stage 2: register the twiddled points
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      x0_2_q <= x0_1_q;
      t1_q   <= t1;
      t2_q   <= t2;
      t3_q   <= t3;
    end
  end

  // Widen to the output format
  assign x0r = OUT_BITS'(x0_2_q.re);
  assign x0i = OUT_BITS'(x0_2_q.im);
  assign t1r = OUT_BITS'(t1_q.re);
  assign t1i = OUT_BITS'(t1_q.im);
  assign t2r = OUT_BITS'(t2_q.re);
  assign t2i = OUT_BITS'(t2_q.im);
  assign t3r = OUT_BITS'(t3_q.re);
  assign t3i = OUT_BITS'(t3_q.im);

  // Radix-4 partial sums
  assign s0r = x0r + t2r;
  assign s0i = x0i + t2i;
  assign s5r = x0r - t2r;
  assign s5i = x0i - t2i;
  assign s3r = t1r + t3r;
  assign s3i = t1i + t3i;
  assign s4r = t1r - t3r;
  assign s4i = t1i - t3i;

  // Stage 3: result register
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      y0r_q <= s0r + s3r;
      y0i_q <= s0i + s3i;
      y1r_q <= s5r + s4i;
      y1i_q <= s5i - s4r;
      y2r_q <= s0r - s3r;
      y2i_q <= s0i - s3i;
      y3r_q <= s5r - s4i;
      y3i_q <= s5i + s4r;
    end
  end

  assign out_o.valid = v3_q;
  assign out_o.y0_re = y0r_q;
  assign out_o.y0_im = y0i_q;
  assign out_o.y1_re = y1r_q;
  assign out_o.y1_im = y1i_q;
  assign out_o.y2_re = y2r_q;
  assign out_o.y2_im = y2i_q;
  assign out_o.y3_re = y3r_q;
  assign out_o.y3_im = y3i_q;

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // A load word never enters the compute pipeline
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && cmd_e'(in_i.command) == CMD_LOAD) |=> !v1_q)
    else $error("load word entered the pipeline");

  // A blocked stage-1 word is kept
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("stage-1 word lost under stall");

  // A blocked stage-2 word is kept
  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && v3_q))
    else $error("stage-2 word lost under stall");

endmodule

>>> sim/radix4_fft_butterfly_tb.sv
// Self-checking testbench for the radix-4 FFT butterfly engine: directed table, then random phases.
module radix4_fft_butterfly_tb;
  import rfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NPHASE       = 8;

  // One input word and the eight output fields (index 0 is y0_re, 7 is y3_im)
  typedef struct packed {
    cmd_e                 cmd;
    logic [SLOT_BITS-1:0] slot;
    sample_t              a_re;
    sample_t              a_im;
    sample_t              b_re;
    sample_t              b_im;
    sample_t              c_re;
    sample_t              c_im;
    sample_t              d_re;
    sample_t              d_im;
  } bfly_word_t;

  typedef logic [7:0][OUT_BITS-1:0] bfly_res_t;

  typedef struct {
    bfly_word_t w;
    bit         pinned;
    bfly_res_t  res;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_data_i;

  rfb_in_if  in_if ();
  rfb_out_if out_if ();

  radix4_fft_butterfly u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state: twiddle table, running indices, butterfly counter, registers
  sample_t              tw_re [TW_DEPTH];
  sample_t              tw_im [TW_DEPTH];
  bit                   tw_loaded [TW_DEPTH];
  logic [TW_AW-1:0]     k1, k2, k3;
  logic [CNT_BITS-1:0]  bfly_cnt;
  logic [CFG_BITS-1:0]  cfg_len, cfg_stride;

  bfly_res_t  bfly_expect_q [$];
  dir_row_t   dir_rows [$];
  int         errors = 0;
  int         cycles = 0;
  int         burst_left = 0;
  string      yname [8] = '{"y0_re", "y0_im", "y1_re", "y1_im",
                            "y2_re", "y2_im", "y3_re", "y3_im"};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result side, switching at random between four stall modes
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left  = $urandom_range(200, 20);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(1));
        2:       out_if.ready <= (cycles % 4 == 0);
        default: out_if.ready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    bfly_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.y3_im, out_if.y3_re, out_if.y2_im, out_if.y2_re,
             out_if.y1_im, out_if.y1_re, out_if.y0_im, out_if.y0_re};
      if (bfly_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word y0_re=%0d", $time, $signed(got[0]));
      end else begin
        want = bfly_expect_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            errors++;
            if (errors <= 60)
              $display("%0t: %s expected %0d got %0d", $time, yname[i],
                       $signed(want[i]), $signed(got[i]));
          end
        end
      end
    end
  end

  // Complex multiply by the stored twiddle, rounded half up and shifted by 15
  function automatic void twiddle_mul(input sample_t xr, input sample_t xi,
                                      input logic [TW_AW-1:0] k,
                                      output longint tr, output longint ti);
    longint wr, wi;
    wr = tw_re[k];
    wi = tw_im[k];
    tr = (longint'(xr) * wr - longint'(xi) * wi + 64'sd16384) >>> (DATA_BITS - 1);
    ti = (longint'(xi) * wr + longint'(xr) * wi + 64'sd16384) >>> (DATA_BITS - 1);
  endfunction

  // Apply one accepted word to the predictor; queue the result of a compute word
  task automatic butterfly_predict(input bfly_word_t w, input bit pinned,
                                   input bfly_res_t pinned_res);
    longint    t1r, t1i, t2r, t2i, t3r, t3i;
    longint    s0r, s0i, s3r, s3i, s4r, s4i, s5r, s5i;
    bfly_res_t r;
    int        len, step;
    if (w.cmd == CMD_LOAD) begin
      tw_re[w.slot]     = w.a_re;
      tw_im[w.slot]     = w.a_im;
      tw_loaded[w.slot] = 1'b1;
    end else begin
      twiddle_mul(w.b_re, w.b_im, k1, t1r, t1i);
      twiddle_mul(w.c_re, w.c_im, k2, t2r, t2i);
      twiddle_mul(w.d_re, w.d_im, k3, t3r, t3i);
      s0r = longint'(w.a_re) + t2r;  s0i = longint'(w.a_im) + t2i;
      s5r = longint'(w.a_re) - t2r;  s5i = longint'(w.a_im) - t2i;
      s3r = t1r + t3r;               s3i = t1i + t3i;
      s4r = t1r - t3r;               s4i = t1i - t3i;
      r[0] = out_t'(s0r + s3r);
      r[1] = out_t'(s0i + s3i);
      r[2] = out_t'(s5r + s4i);
      r[3] = out_t'(s5i - s4r);
      r[4] = out_t'(s0r - s3r);
      r[5] = out_t'(s0i - s3i);
      r[6] = out_t'(s5r - s4i);
      r[7] = out_t'(s5i + s4r);
      bfly_expect_q.push_back(pinned ? pinned_res : r);

      // Advance the indices, or restart them when the group wraps
      len  = (cfg_len == 0) ? 1 : ((cfg_len > LEN_MAX) ? LEN_MAX : int'(cfg_len));
      step = int'(cfg_stride) % TW_DEPTH;
      if (int'(bfly_cnt) + 1 >= len) begin
        bfly_cnt = '0;
        k1 = '0;
        k2 = '0;
        k3 = '0;
      end else begin
        bfly_cnt = bfly_cnt + 1'b1;
        k1 = TW_AW'((int'(k1) + step) % TW_DEPTH);
        k2 = TW_AW'((int'(k2) + 2 * step) % TW_DEPTH);
        k3 = TW_AW'((int'(k3) + 3 * step) % TW_DEPTH);
      end
    end
  endtask

  // Drive one word in bursts with random gaps; predict once it is taken
  task automatic send_word(input bfly_word_t w, input bit pinned = 1'b0,
                           input bfly_res_t pinned_res = '0);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 60) : $urandom_range(30, 1);
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.command      <= w.cmd;
    in_if.twiddle_slot <= w.slot;
    in_if.a_re         <= w.a_re;
    in_if.a_im         <= w.a_im;
    in_if.b_re         <= w.b_re;
    in_if.b_im         <= w.b_im;
    in_if.c_re         <= w.c_re;
    in_if.c_im         <= w.c_im;
    in_if.d_re         <= w.d_re;
    in_if.d_im         <= w.d_im;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    butterfly_predict(w, pinned, pinned_res);
  endtask

  // Drop valid and wait for every expected word, then for the pipeline to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (bfly_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_BITS-1:0] len, input logic [CFG_BITS-1:0] stride);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SUB_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= REG_TWIDDLE_STRIDE;
    cfg_data_i <= stride;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_len    = len;
    cfg_stride = stride;
  endtask

  // Mostly uniform samples, with the corner values mixed in
  function automatic sample_t rand_sample();
    case ($urandom_range(11))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2:       return sample_t'(16'h0000);
      3:       return sample_t'(16'hFFFF);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic bfly_word_t rand_word(input cmd_e cmd, input int slot);
    bfly_word_t w;
    w.cmd  = cmd;
    w.slot = SLOT_BITS'(slot);
    w.a_re = rand_sample();  w.a_im = rand_sample();
    w.b_re = rand_sample();  w.b_im = rand_sample();
    w.c_re = rand_sample();  w.c_im = rand_sample();
    w.d_re = rand_sample();  w.d_im = rand_sample();
    return w;
  endfunction

  // Table row; a pinned row has all four outputs equal to (er, ei)
  task automatic add_row(input cmd_e cmd, input int slot, input int ar, input int ai,
                         input int br, input int bi, input int cr, input int ci,
                         input int dr, input int di, input bit pinned = 1'b0,
                         input int er = 0, input int ei = 0);
    dir_row_t row;
    row.w = '{cmd, SLOT_BITS'(slot), sample_t'(ar), sample_t'(ai), sample_t'(br),
              sample_t'(bi), sample_t'(cr), sample_t'(ci), sample_t'(dr), sample_t'(di)};
    row.pinned = pinned;
    for (int i = 0; i < 4; i++) begin
      row.res[2*i]   = out_t'(er);
      row.res[2*i+1] = out_t'(ei);
    end
    dir_rows.push_back(row);
  endtask

  initial begin
    int phase_len    [NPHASE] = '{4, 0, 256, 511, 5, 7, 256, 3};
    int phase_stride [NPHASE] = '{1, 3, 511, 256, 0, 200, 1, 341};
    int phase_items  [NPHASE] = '{60, 40, 150, 60, 40, 80, 60, 60};

    // Hold every input at a known value through reset
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_SUB_LENGTH;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_LOAD;
    in_if.twiddle_slot = '0;
    in_if.a_re = '0;  in_if.a_im = '0;
    in_if.b_re = '0;  in_if.b_im = '0;
    in_if.c_re = '0;  in_if.c_im = '0;
    in_if.d_re = '0;  in_if.d_im = '0;
    out_if.ready       = 1'b0;
    bfly_cnt   = '0;
    k1 = '0;  k2 = '0;  k3 = '0;
    cfg_len    = CFG_BITS'(1);
    cfg_stride = CFG_BITS'(1);
    for (int i = 0; i < TW_DEPTH; i++) tw_loaded[i] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; after reset the group length is one, so every
    // butterfly reads slot 0 for all three points
    // zero twiddle: every output equals x0
    add_row(CMD_LOAD,    0,      0,      0,     -1,     -1,     -1,     -1,     -1,    -1);
    add_row(CMD_COMPUTE, 0, -32768,  32767,  32767,  32767,  32767,  32767,  32767, 32767,
            1'b1, -32768, 32767);
    add_row(CMD_COMPUTE, 1023, 32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
            1'b1, 32767, -32768);
    // table edge slot, never read while the length stays at one
    add_row(CMD_LOAD,    1023,  32767, -32768,   0,      0,      0,      0,      0,     0);
    // twiddle of minus one
    add_row(CMD_LOAD,    0, -32768,      0,      0,      0,      0,      0,      0,     0);
    add_row(CMD_COMPUTE, 0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_row(CMD_COMPUTE, 0,  32767,  32767,  32767,  32767,  32767,  32767,  32767, 32767);
    add_row(CMD_COMPUTE, 0,      0,      0, -32768, -32768,  32767,  32767, -32768, 32767);
    // largest product magnitude
    add_row(CMD_LOAD,    0, -32768, -32768,  32767,  32767,  32767,  32767,  32767, 32767);
    add_row(CMD_COMPUTE, 0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_row(CMD_COMPUTE, 0,  32767, -32768,  32767, -32768, -32768,  32767,  32767, -32768);
    add_row(CMD_LOAD,    0,  32767,  32767,      0,      0,      0,      0,      0,     0);
    add_row(CMD_COMPUTE, 0,  32767,  32767,  32767,  32767,  32767,  32767,  32767, 32767);
    add_row(CMD_COMPUTE, 0,   1234,  -4321,  20000, -20000,   -777,    777,  16384, -16384);
    // eighth-turn twiddle; zero points give zero, small points probe rounding
    add_row(CMD_LOAD,    0,  23170, -23170,      0,      0,      0,      0,      0,     0);
    add_row(CMD_COMPUTE, 0,      0,      0,      0,      0,      0,      0,      0,     0,
            1'b1, 0, 0);
    add_row(CMD_COMPUTE, 0,      1,     -1,     -1,      1,      1,      1,     -1,    -1);
    add_row(CMD_LOAD,    512,    0,  32767,      0,      0,      0,      0,      0,     0);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].pinned, dir_rows[i].res);
    drain();

    // Random phases over several register settings, the extremes among them
    for (int p = 0; p < NPHASE; p++) begin
      set_config(CFG_BITS'(phase_len[p]), CFG_BITS'(phase_stride[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(9) < 3) begin
          send_word(rand_word(CMD_LOAD, $urandom_range(TW_DEPTH - 1)));
        end else begin
          // Load any twiddle this butterfly would read before it was written
          if (!tw_loaded[k1]) send_word(rand_word(CMD_LOAD, int'(k1)));
          if (!tw_loaded[k2]) send_word(rand_word(CMD_LOAD, int'(k2)));
          if (!tw_loaded[k3]) send_word(rand_word(CMD_LOAD, int'(k3)));
          send_word(rand_word(CMD_COMPUTE, $urandom_range(TW_DEPTH - 1)));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rfb_pkg.sv
rtl/core/rfb_if.sv
rtl/core/rfb_index_ctrl.sv
rtl/core/rfb_twiddle_store.sv
rtl/core/rfb_cmul.sv
rtl/core/radix4_fft_butterfly.sv
sim/radix4_fft_butterfly_tb.sv
